// File: design/pcbp_pkg.sv
// Shared types and constants for the prefix code bit packer.
`timescale 1ns / 1ps

package pcbp_pkg;

    localparam int DEF_SYMBOL_COUNT  = 256;
    localparam int DEF_MAX_CODE_BITS = 64;

    localparam int SYM_W   = 8;
    localparam int BITS_W  = 64;
    localparam int LEN_W   = 7;
    localparam int BYTE_W  = 8;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_RAW    = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT
    } state_t;

endpackage

// File: design/pcbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/prefix_code_bit_packer.sv
// Prefix code bit packer: code table in RAM, MSB-first byte packing with output register.
// An encode is accepted, then the table is read and the first packing step runs with the
// read; each further packing step follows in ST_SHIFT. A load is done at acceptance. A raw
// write or a flush is accepted and then runs its packing steps. A step places up to eight bits
// and completes at most one byte; a partly filled final byte costs a step of its own.
// Packing completes one byte per cycle while the output takes it; an output stall holds the
// step. Reset clears the valid marks at once and leaves an empty byte, MSB next.
`timescale 1ns / 1ps

module prefix_code_bit_packer
    import pcbp_pkg::*;
#(
    parameter int SYMBOL_COUNT  = DEF_SYMBOL_COUNT,
    parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    input  logic [SYM_W-1:0]  symbol,
    input  logic [BITS_W-1:0] code_bits,
    input  logic [LEN_W-1:0]  code_length,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              error,
    output logic              last
);

    localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
    localparam int SLEN_W  = $clog2(MAX_CODE_BITS + 1);
    localparam int WORD_W  = SLEN_W + MAX_CODE_BITS;

    state_t state_reg, state_next;

    logic [SYMBOL_COUNT-1:0] valid_reg, valid_next;
    logic                    hit_reg, hit_next;
    logic [BYTE_W-1:0]       partial_reg, partial_next;
    logic [2:0]              pos_reg, pos_next;
    logic [BITS_W-1:0]       sh_reg, sh_next;
    logic [LEN_W-1:0]        rem_reg, rem_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              error_reg, error_next;
    logic              last_reg, last_next;

    logic              in_fire;
    logic              out_free;
    op_t               op_in;
    logic [ADDR_W-1:0] addr;
    logic              sym_in_range;
    logic [LEN_W-1:0]  len_clamped;

    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [WORD_W-1:0] ram_rd_data;
    logic [MAX_CODE_BITS-1:0] ram_code;
    logic [SLEN_W-1:0] ram_len;

    logic [BITS_W-1:0] src_sh;
    logic [LEN_W-1:0]  src_rem;
    logic [3:0]        free_cnt;
    logic              fill;
    logic [LEN_W-1:0]  rem_after;
    logic [BYTE_W-1:0] chunk;
    logic              step_ok;
    logic              step_done;

    assign in_ready     = (state_reg == ST_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign out_free     = !out_valid_reg || out_ready;
    assign op_in        = op_t'(op);
    assign addr         = symbol[ADDR_W-1:0];
    assign sym_in_range = ({1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign len_clamped  = (code_length > LEN_W'(MAX_CODE_BITS)) ?
                          LEN_W'(MAX_CODE_BITS) : code_length;

    assign ram_wr_en = in_fire && (op_in == OP_LOAD) && sym_in_range;
    assign ram_rd_en = in_fire && (op_in == OP_ENCODE);
    assign ram_code  = ram_rd_data[MAX_CODE_BITS-1:0];
    assign ram_len   = ram_rd_data[WORD_W-1:MAX_CODE_BITS];

    // Code word and length share one table word. Only one item is in flight, so a load and
    // a later encode of the same entry never overlap in the RAM.
    pcbp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (addr),
        .wr_data ({SLEN_W'(len_clamped), code_bits[MAX_CODE_BITS-1:0]}),
        .rd_en   (ram_rd_en),
        .rd_addr (addr),
        .rd_data (ram_rd_data)
    );

    // Pending bits sit left aligned with zeros below them, so the top byte shifted down by
    // the used slots drops straight into the partial byte without masking.
    always_comb
    begin
        if (state_reg == ST_READ)
        begin
            src_sh  = BITS_W'(ram_code) << (LEN_W'(BITS_W) - LEN_W'(ram_len));
            src_rem = LEN_W'(ram_len);
        end
        else
        begin
            src_sh  = sh_reg;
            src_rem = rem_reg;
        end
        free_cnt  = {1'b0, pos_reg} + 4'd1;
        fill      = (src_rem >= LEN_W'(free_cnt));
        rem_after = src_rem - LEN_W'(free_cnt);
        chunk     = src_sh[BITS_W-1 -: BYTE_W] >> (~pos_reg);
        step_ok   = !fill || out_free;
        step_done = !fill || (rem_after == '0);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (op_in)
                        OP_ENCODE: state_next = ST_READ;
                        OP_RAW:    state_next = (len_clamped != '0) ? ST_SHIFT : ST_IDLE;
                        OP_FLUSH:  state_next = (pos_reg != 3'd7) ? ST_SHIFT : ST_IDLE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:
            begin
                if (!hit_reg)
                begin
                    state_next = out_free ? ST_IDLE : ST_READ;
                end
                else if (step_ok)
                begin
                    state_next = step_done ? ST_IDLE : ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (step_ok && step_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        valid_next     = valid_reg;
        hit_next       = hit_reg;
        partial_next   = partial_reg;
        pos_next       = pos_reg;
        sh_next        = sh_reg;
        rem_next       = rem_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        out_byte_next  = out_byte_reg;
        error_next     = error_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (op_in)
                        OP_LOAD:
                        begin
                            if (sym_in_range)
                            begin
                                valid_next[addr] = 1'b1;
                            end
                        end
                        OP_ENCODE:
                        begin
                            hit_next = sym_in_range && valid_reg[addr];
                        end
                        OP_RAW:
                        begin
                            sh_next  = code_bits << (LEN_W'(BITS_W) - len_clamped);
                            rem_next = len_clamped;
                        end
                        default:
                        begin
                            sh_next  = '0;
                            rem_next = LEN_W'(free_cnt);
                        end
                    endcase
                end
            end
            default:
            begin
                if ((state_reg == ST_READ) && !hit_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = '0;
                        error_next     = 1'b1;
                        last_next      = 1'b1;
                    end
                end
                else if (step_ok)
                begin
                    if (fill)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = partial_reg | chunk;
                        error_next     = 1'b0;
                        // After a full byte the next one completes only if eight bits remain.
                        last_next      = (rem_after < LEN_W'(BYTE_W));
                        partial_next   = '0;
                        pos_next       = 3'd7;
                        sh_next        = src_sh << free_cnt;
                        rem_next       = rem_after;
                    end
                    else
                    begin
                        partial_next = partial_reg | chunk;
                        pos_next     = pos_reg - src_rem[2:0];
                        rem_next     = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            partial_reg   <= '0;
            pos_reg       <= 3'd7;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            partial_reg   <= partial_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        sh_reg       <= sh_next;
        out_byte_reg <= out_byte_next;
        error_reg    <= error_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign error     = error_reg;
    assign last      = last_reg;

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && error_reg |-> last_reg && (out_byte_reg == '0))
        else $error("error result must be a final zero byte");

    a_empty_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == 3'd7) |-> (partial_reg == '0))
        else $error("partial byte holds bits while the MSB is next");

    a_shift_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (rem_reg != '0))
        else $error("packing step entered with no pending bits");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("item accepted while a previous item is still packing");

endmodule

// File: bench/prefix_code_bit_packer_check.sv
// Checker for the prefix code bit packer: predicts the packed bytes and compares them.
`timescale 1ns / 1ps

module prefix_code_bit_packer_check
    import pcbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [1:0]        op,
    input  logic [SYM_W-1:0]  symbol,
    input  logic [BITS_W-1:0] code_bits,
    input  logic [LEN_W-1:0]  code_length,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [BYTE_W-1:0] out_byte,
    input  logic              error,
    input  logic              last,
    output int                fail_count,
    output int                waiting_count
);

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              err;
        logic              tail;
    } packed_out_t;

    logic [BITS_W-1:0] code_tab [DEF_SYMBOL_COUNT];
    logic [LEN_W-1:0]  len_tab  [DEF_SYMBOL_COUNT];
    logic              loaded   [DEF_SYMBOL_COUNT];
    logic [BYTE_W-1:0] pend_byte;
    logic [2:0]        next_pos;
    packed_out_t       byte_queue [$];
    packed_out_t       item_bytes [$];

    function automatic int clamp_len(input logic [LEN_W-1:0] raw_len);
        return (raw_len > DEF_MAX_CODE_BITS) ? DEF_MAX_CODE_BITS : int'(raw_len);
    endfunction

    function automatic logic [BITS_W-1:0] keep_low(input logic [BITS_W-1:0] word, input int n);
        return (n >= BITS_W) ? word : (word & ((64'd1 << n) - 64'd1));
    endfunction

    // Places bits MSB first; a byte is complete once bit 0 has been written.
    task automatic append_code(input logic [BITS_W-1:0] word, input int count);
        for (int i = count - 1; i >= 0; i--) begin
            pend_byte[next_pos] = word[i];
            if (next_pos == 3'd0) begin
                item_bytes.push_back('{value: pend_byte, err: 1'b0, tail: 1'b0});
                pend_byte = '0;
                next_pos  = 3'd7;
            end
            else begin
                next_pos = next_pos - 3'd1;
            end
        end
    endtask

    task automatic pack_item(input op_t kind, input logic [SYM_W-1:0] sym,
                             input logic [BITS_W-1:0] word, input logic [LEN_W-1:0] raw_len);
        int          n;
        packed_out_t final_out;
        n = clamp_len(raw_len);
        item_bytes.delete();
        case (kind)
            OP_LOAD:
            begin
                code_tab[sym] = keep_low(word, n);
                len_tab[sym]  = LEN_W'(n);
                loaded[sym]   = 1'b1;
            end
            OP_ENCODE:
            begin
                if (loaded[sym])
                    append_code(code_tab[sym], clamp_len(len_tab[sym]));
                else
                    item_bytes.push_back('{value: '0, err: 1'b1, tail: 1'b0});
            end
            OP_RAW:
            begin
                append_code(word, n);
            end
            default:
            begin
                if (next_pos != 3'd7)
                    append_code('0, int'(next_pos) + 1);
            end
        endcase
        if (item_bytes.size() > 0) begin
            final_out      = item_bytes.pop_back();
            final_out.tail = 1'b1;
            item_bytes.push_back(final_out);
        end
        foreach (item_bytes[k])
            byte_queue.push_back(item_bytes[k]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        packed_out_t want;
        if (!rst_n) begin
            foreach (loaded[k])
                loaded[k] = 1'b0;
            pend_byte  = '0;
            next_pos   = 3'd7;
            fail_count = 0;
            byte_queue.delete();
        end
        else begin
            if (out_valid && out_ready) begin
                if (byte_queue.size() == 0) begin
                    $error("unexpected result: out_byte %02h, error %0b, last %0b",
                           out_byte, error, last);
                    fail_count++;
                end
                else begin
                    want = byte_queue.pop_front();
                    if (out_byte !== want.value) begin
                        $error("out_byte: expected %02h, actual %02h", want.value, out_byte);
                        fail_count++;
                    end
                    if (error !== want.err) begin
                        $error("error: expected %0b, actual %0b", want.err, error);
                        fail_count++;
                    end
                    if (last !== want.tail) begin
                        $error("last: expected %0b, actual %0b", want.tail, last);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                pack_item(op_t'(op), symbol, code_bits, code_length);
        end
        waiting_count = byte_queue.size();
    end

endmodule

// File: bench/prefix_code_bit_packer_test.sv
// Top of the prefix code bit packer bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module prefix_code_bit_packer_test;
    import pcbp_pkg::*;

    localparam int RANDOM_ITEMS = 320;
    localparam int CALM_ITEMS   = 40;
    localparam int CYCLE_LIMIT  = 500000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        op;
    logic [SYM_W-1:0]  symbol;
    logic [BITS_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              out_valid;
    logic              out_ready;
    logic [BYTE_W-1:0] out_byte;
    logic              error;
    logic              last;
    int                fail_count;
    int                waiting_count;
    int                cycle_count;

    // Idling is switched on and off in stretches; calm turns it off for good.
    bit                idle_on;
    bit                calm;
    bit                is_loaded [DEF_SYMBOL_COUNT];
    logic [SYM_W-1:0]  loaded_syms [$];

    prefix_code_bit_packer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .error       (error),
        .last        (last)
    );

    prefix_code_bit_packer_check chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .symbol        (symbol),
        .code_bits     (code_bits),
        .code_length   (code_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .error         (error),
        .last          (last),
        .fail_count    (fail_count),
        .waiting_count (waiting_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [BITS_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly short codes, with some long, overlong and empty ones.
    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 7)
            return '0;
        else if (r < 72)
            return LEN_W'($urandom_range(1, 12));
        else if (r < 90)
            return LEN_W'($urandom_range(13, 64));
        else
            return LEN_W'($urandom_range(65, 127));
    endfunction

    task automatic hold_off(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_item(input op_t kind, input logic [SYM_W-1:0] sym,
                             input logic [BITS_W-1:0] word, input logic [LEN_W-1:0] len);
        if (!calm && idle_on && $urandom_range(3) == 0)
            hold_off($urandom_range(1, 18));
        @(negedge clk);
        in_valid    <= 1'b1;
        op          <= kind;
        symbol      <= sym;
        code_bits   <= word;
        code_length <= len;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (kind == OP_LOAD && !is_loaded[sym]) begin
            is_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    initial
    begin
        int run;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            run = $urandom_range(1, 18);
            @(negedge clk);
            out_ready <= 1'b1;
            repeat (run - 1) @(negedge clk);
            if (!calm && idle_on && $urandom_range(2) != 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        int               r;
        logic [SYM_W-1:0] sym;
        in_valid    = 1'b0;
        op          = OP_LOAD;
        symbol      = '0;
        code_bits   = '0;
        code_length = '0;
        idle_on     = 1'b1;
        calm        = 1'b0;
        rst_n       = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: unloaded symbols, empty flushes, zero and overlong lengths.
        send_item(OP_ENCODE, 8'h00, rand_word(), 7'd5);
        send_item(OP_FLUSH, 8'hFF, '1, 7'd127);
        send_item(OP_RAW, 8'h00, '1, 7'd0);
        send_item(OP_LOAD, 8'hFF, '1, 7'd64);
        send_item(OP_LOAD, 8'h00, 64'hFFFF_FFFF_FFFF_FFF5, 7'd3);
        send_item(OP_LOAD, 8'h5A, 64'hA5C3_0F96_1E2D_3C4B, 7'd127);
        send_item(OP_LOAD, 8'h01, '1, 7'd0);
        send_item(OP_ENCODE, 8'h00, '0, 7'd0);
        send_item(OP_ENCODE, 8'h01, '1, 7'd127);
        send_item(OP_ENCODE, 8'hFF, '0, 7'd0);
        send_item(OP_ENCODE, 8'h5A, rand_word(), 7'd9);
        send_item(OP_RAW, 8'hFF, '1, 7'd65);
        send_item(OP_RAW, 8'h00, '0, 7'd64);
        send_item(OP_RAW, 8'h00, 64'h1, 7'd1);
        send_item(OP_FLUSH, 8'h00, '0, 7'd0);
        send_item(OP_FLUSH, 8'h00, '0, 7'd0);
        send_item(OP_RAW, 8'h00, 64'h55, 7'd7);
        send_item(OP_RAW, 8'h00, 64'h1, 7'd1);
        send_item(OP_LOAD, 8'h80, '0, 7'd1);
        send_item(OP_ENCODE, 8'h80, '0, 7'd0);
        send_item(OP_ENCODE, 8'h7E, '1, 7'd64);
        send_item(OP_LOAD, 8'h00, rand_word(), 7'd12);
        send_item(OP_ENCODE, 8'h00, '0, 7'd0);
        send_item(OP_RAW, 8'h00, '0, 7'd127);
        send_item(OP_FLUSH, 8'h00, '0, 7'd0);

        // Random part: encodes mostly pick symbols that have been loaded.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 25 == 0)
                idle_on = ($urandom_range(2) != 0);
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            r = $urandom_range(99);
            if (r < 15) begin
                send_item(OP_LOAD, SYM_W'($urandom_range(255)), rand_word(), pick_len());
            end
            else if (r < 70) begin
                if (loaded_syms.size() > 0 && $urandom_range(9) != 0)
                    sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
                else
                    sym = SYM_W'($urandom_range(255));
                send_item(OP_ENCODE, sym, rand_word(), LEN_W'($urandom_range(127)));
            end
            else if (r < 88) begin
                send_item(OP_RAW, SYM_W'($urandom_range(255)), rand_word(), pick_len());
            end
            else begin
                send_item(OP_FLUSH, SYM_W'($urandom_range(255)), rand_word(),
                          LEN_W'($urandom_range(127)));
            end
        end
        hold_off(1);

        while (waiting_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
design/pcbp_pkg.sv
design/pcbp_ram.sv
design/prefix_code_bit_packer.sv
bench/prefix_code_bit_packer_check.sv
bench/prefix_code_bit_packer_test.sv
